// ===== hw/rtl/jsu_pkg.sv =====
// jsu_pkg: types and character constants for the JSON string unescaper.
// No dependencies; taken in by the decoder, the top level and the bench.
package jsu_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX  = 3'd3,
        PH_DONE = 3'd4,
        PH_ERR  = 3'd5
    } t_phase;

    // Result status codes
    typedef enum logic [1:0] {
        ST_RUN = 2'd0,
        ST_OK  = 2'd1,
        ST_ERR = 2'd2,
        ST_IGN = 2'd3
    } t_status;

    localparam int unsigned NumHexDigits = 4;

    // Characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_FF = 8'h66;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_U  = 8'h75;

    // Control codes the short escapes map to
    localparam logic [15:0] CC_BS = 16'h0008;
    localparam logic [15:0] CC_FF = 16'h000C;
    localparam logic [15:0] CC_LF = 16'h000A;
    localparam logic [15:0] CC_CR = 16'h000D;
    localparam logic [15:0] CC_HT = 16'h0009;

    // Parser state carried between bytes
    typedef struct packed {
        t_phase      phase;
        logic [1:0]  hex_count;
        logic [15:0] hex_accum;
    } t_state;

    // One result item
    typedef struct packed {
        logic [15:0] unit;
        logic        unit_valid;
        t_status     status;
    } t_result;

endpackage

// ===== hw/rtl/jsu_in_if.sv =====
// jsu_in_if: valid/ready channel carrying one string byte per transfer.
// No dependencies.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       first;

    modport source (output valid, byte_in, first, input ready);
    modport sink   (input valid, byte_in, first, output ready);
endinterface

// ===== hw/rtl/jsu_out_if.sv =====
// jsu_out_if: valid/ready channel carrying one decoded result per transfer.
// No dependencies.
interface jsu_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] unit;
    logic        unit_valid;
    logic [1:0]  status;

    modport source (output valid, unit, unit_valid, status, input ready);
    modport sink   (input valid, unit, unit_valid, status, output ready);
endinterface

// ===== hw/rtl/jsu_decode.sv =====
// jsu_decode: combinational next-state and result logic for one byte.
// Depends on jsu_pkg.
module jsu_decode
    import jsu_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic       i_first,
    output t_state     o_state,
    output t_result    o_result
);

    // Hex digit value, 16 when the byte is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [7:0] v;
        v = 8'd16;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            v = b - CH_ZERO;
        end else if (b >= CH_UC_A && b <= CH_UC_F) begin
            v = b - CH_UC_A + 8'd10;
        end else if (b >= CH_LC_A && b <= CH_LC_F) begin
            v = b - CH_LC_A + 8'd10;
        end
        return v[4:0];
    endfunction

    logic [4:0]  hex_d;
    logic [15:0] hex_next;

    assign hex_d    = hex_value(i_byte);
    assign hex_next = {i_state.hex_accum[11:0], hex_d[3:0]};

    // Next state and result
    always_comb begin
        o_state             = i_state;
        o_result.unit       = '0;
        o_result.unit_valid = 1'b0;
        o_result.status     = ST_RUN;

        if (i_first) begin
            // a new string always restarts, whatever was in progress
            o_state.hex_count = '0;
            o_state.hex_accum = '0;
            if (i_byte == CH_QUOTE) begin
                o_state.phase = PH_BODY;
            end else begin
                o_state.phase   = PH_ERR;
                o_result.status = ST_ERR;
            end
        end else begin
            unique case (i_state.phase)
                PH_BODY: begin
                    priority if (i_byte == CH_QUOTE) begin
                        o_state.phase   = PH_DONE;
                        o_result.status = ST_OK;
                    end else if (i_byte == CH_NUL) begin
                        o_state.phase   = PH_ERR;
                        o_result.status = ST_ERR;
                    end else if (i_byte == CH_BSL) begin
                        o_state.phase = PH_ESC;
                    end else begin
                        o_result.unit       = {8'h00, i_byte};
                        o_result.unit_valid = 1'b1;
                    end
                end
                PH_ESC: begin
                    priority if (i_byte == CH_NUL) begin
                        o_state.phase   = PH_ERR;
                        o_result.status = ST_ERR;
                    end else if (i_byte == CH_LC_U) begin
                        o_state.phase     = PH_HEX;
                        o_state.hex_count = '0;
                        o_state.hex_accum = '0;
                    end else begin
                        o_state.phase       = PH_BODY;
                        o_result.unit_valid = 1'b1;
                        unique case (i_byte)
                            CH_LC_B:  o_result.unit = CC_BS;
                            CH_LC_FF: o_result.unit = CC_FF;
                            CH_LC_N:  o_result.unit = CC_LF;
                            CH_LC_R:  o_result.unit = CC_CR;
                            CH_LC_T:  o_result.unit = CC_HT;
                            default:  o_result.unit = {8'h00, i_byte};
                        endcase
                    end
                end
                PH_HEX: begin
                    if (hex_d[4]) begin
                        o_state.phase     = PH_ERR;
                        o_state.hex_count = '0;
                        o_state.hex_accum = '0;
                        o_result.status   = ST_ERR;
                    end else if (i_state.hex_count == 2'(NumHexDigits - 1)) begin
                        // last digit: emit the gathered code unit
                        o_state.phase       = PH_BODY;
                        o_state.hex_count   = '0;
                        o_state.hex_accum   = '0;
                        o_result.unit       = hex_next;
                        o_result.unit_valid = 1'b1;
                    end else begin
                        o_state.hex_count = i_state.hex_count + 2'd1;
                        o_state.hex_accum = hex_next;
                    end
                end
                default: begin
                    // idle, done, error and unused codes: no string open
                    o_result.status = ST_IGN;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/json_string_unescape.sv =====
// json_string_unescape: one byte in, one UTF-16 result out per transfer.
// Each byte passes through the input register, is decoded, and its result is held in the result register.
// Throughput: one byte per cycle while the output is not stalled, set by the single decode stage and its state update.
// Backpressure on the output stalls the input register; the result register holds while stalled.
// Reset (synchronous, active low) empties both stages and returns the parser to idle.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if and jsu_decode.
module json_string_unescape
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;

    t_state     r_state;
    t_state     n_state;
    t_result    n_result;

    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       advance;

    // Stage handshakes: the result register frees when empty or taken
    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte  <= i_in.byte_in;
            r_in_first <= i_in.first;
        end
    end

    // Decode
    jsu_decode u_decode (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_first  (r_in_first),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Parser state, updated as each byte moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase     <= PH_IDLE;
            r_state.hex_count <= '0;
            r_state.hex_accum <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.unit       = r_out.unit;
    assign o_out.unit_valid = r_out.unit_valid;
    assign o_out.status     = r_out.status;

`ifndef SYNTHESIS
    // Hex digits are only counted while inside a unicode escape
    a_hex_count_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.hex_count != 2'd0 |-> r_state.phase == PH_HEX)
        else $error("hex count set outside hex phase");

    // An error result leaves the parser in the error phase
    a_err_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_result.status == ST_ERR |=> r_state.phase == PH_ERR)
        else $error("error result without error phase");

    // A code unit is only emitted while a string is running
    a_unit_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.unit_valid |-> r_out.status == ST_RUN)
        else $error("code unit with non-running status");

    // Empty results carry a zero unit
    a_unit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !n_result.unit_valid |-> n_result.unit == 16'h0000)
        else $error("non-zero unit without unit_valid");
`endif

endmodule

// ===== sim/json_string_unescape_tb.sv =====
// json_string_unescape_tb: self-checking bench for the JSON string unescaper.
// Drives quoted strings byte by byte, predicts each result and checks it on
// the output channel. Depends on jsu_pkg, jsu_in_if, jsu_out_if and the RTL.
`timescale 1ns / 100ps

module json_string_unescape_tb;
    import jsu_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 10;
    localparam int ITEMS_PER_PH = 400;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_CYCLES   = 400000;

    // Directed stimulus row; res is only used where typed is set
    typedef struct packed {
        logic [7:0] b;
        logic       f;
        logic       typed;
        t_result    res;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescape dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predicted parser state
    t_phase      str_phase;
    logic [1:0]  hex_cnt;
    logic [15:0] hex_acc;

    t_result  expected_units[$];
    t_dir_row dir_rows[$];

    int fail_count   = 0;
    int sent_bytes   = 0;
    int cycle_count  = 0;
    int src_idle_pct = 28;
    int snk_idle_pct = 86;
    int hold_left    = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("json_string_unescape_tb failed");
            $finish;
        end
    end

    // Queue tails for expected results and directed rows
    function automatic void add_expected(input t_result r);
        expected_units.insert(expected_units.size(), r);
    endfunction

    function automatic void add_row(input t_dir_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // Hex digit value, bit 4 set when the byte is not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        if (b >= CH_ZERO && b <= CH_NINE) return 5'(b - CH_ZERO);
        if (b >= CH_UC_A && b <= CH_UC_F) return 5'(b - CH_UC_A + 8'd10);
        if (b >= CH_LC_A && b <= CH_LC_F) return 5'(b - CH_LC_A + 8'd10);
        return 5'h10;
    endfunction

    // Advance the predicted parser by one byte and give its result
    task automatic unescape_predict(input logic [7:0] b, input logic f, output t_result r);
        logic [4:0] digit;
        r.unit       = '0;
        r.unit_valid = 1'b0;
        r.status     = ST_RUN;
        if (f) begin
            // a marked byte always restarts, whatever was in progress
            hex_cnt = '0;
            hex_acc = '0;
            if (b == CH_QUOTE) begin
                str_phase = PH_BODY;
            end else begin
                str_phase = PH_ERR;
                r.status  = ST_ERR;
            end
        end else begin
            case (str_phase)
                PH_BODY: begin
                    if (b == CH_QUOTE) begin
                        str_phase = PH_DONE;
                        r.status  = ST_OK;
                    end else if (b == CH_NUL) begin
                        str_phase = PH_ERR;
                        r.status  = ST_ERR;
                    end else if (b == CH_BSL) begin
                        str_phase = PH_ESC;
                    end else begin
                        r.unit       = {8'h00, b};
                        r.unit_valid = 1'b1;
                    end
                end
                PH_ESC: begin
                    if (b == CH_NUL) begin
                        str_phase = PH_ERR;
                        r.status  = ST_ERR;
                    end else if (b == CH_LC_U) begin
                        str_phase = PH_HEX;
                        hex_cnt   = '0;
                        hex_acc   = '0;
                    end else begin
                        str_phase    = PH_BODY;
                        r.unit_valid = 1'b1;
                        case (b)
                            CH_LC_B:  r.unit = CC_BS;
                            CH_LC_FF: r.unit = CC_FF;
                            CH_LC_N:  r.unit = CC_LF;
                            CH_LC_R:  r.unit = CC_CR;
                            CH_LC_T:  r.unit = CC_HT;
                            default:  r.unit = {8'h00, b};
                        endcase
                    end
                end
                PH_HEX: begin
                    digit = hex_digit(b);
                    if (digit[4]) begin
                        str_phase = PH_ERR;
                        hex_cnt   = '0;
                        hex_acc   = '0;
                        r.status  = ST_ERR;
                    end else begin
                        hex_acc = {hex_acc[11:0], digit[3:0]};
                        if (hex_cnt == 2'(NumHexDigits - 1)) begin
                            r.unit       = hex_acc;
                            r.unit_valid = 1'b1;
                            str_phase    = PH_BODY;
                            hex_cnt      = '0;
                            hex_acc      = '0;
                        end else begin
                            hex_cnt = hex_cnt + 2'd1;
                        end
                    end
                end
                // idle, done, error and the unused codes
                default: r.status = ST_IGN;
            endcase
        end
    endtask

    // Present one byte, returning at the edge where it transfers
    task automatic offer_byte(input logic [7:0] b, input logic f);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.byte_in <= b;
        in_ch.first   <= f;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic f);
        t_result pred;
        offer_byte(b, f);
        unescape_predict(b, f, pred);
        add_expected(pred);
        sent_bytes++;
    endtask

    function automatic t_dir_row chk_row(input logic [7:0] b, input logic f,
                                         input logic [15:0] unit, input logic uv,
                                         input t_status st);
        t_dir_row r;
        r.b              = b;
        r.f              = f;
        r.typed          = 1'b1;
        r.res.unit       = unit;
        r.res.unit_valid = uv;
        r.res.status     = st;
        return r;
    endfunction

    function automatic t_dir_row pred_row(input logic [7:0] b, input logic f);
        t_dir_row r;
        r       = '0;
        r.b     = b;
        r.f     = f;
        return r;
    endfunction

    function automatic logic [7:0] hex_char();
        logic [3:0] d;
        d = 4'($urandom_range(15));
        if (d < 4'd10) return CH_ZERO + 8'(d);
        return ($urandom_range(1) ? CH_UC_A : CH_LC_A) + 8'(d - 4'd10);
    endfunction

    // Any byte that is neither a quote, a backslash nor NUL
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSL);
        return b;
    endfunction

    // Byte after a backslash, other than u
    function automatic logic [7:0] esc_byte();
        logic [7:0] b;
        case ($urandom_range(7))
            0: b = CH_LC_B;
            1: b = CH_LC_FF;
            2: b = CH_LC_N;
            3: b = CH_LC_R;
            4: b = CH_LC_T;
            5: b = CH_QUOTE;
            6: b = CH_BSL;
            default: do b = 8'($urandom_range(1, 255)); while (b == CH_LC_U);
        endcase
        return b;
    endfunction

    // One string: mostly well formed, sometimes broken part way
    task automatic random_string();
        int n_tokens;
        int kind;
        int n_digits;
        send_byte(CH_QUOTE, 1'b1);
        n_tokens = $urandom_range(10);
        for (int k = 0; k < n_tokens; k++) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                send_byte(plain_byte(), 1'b0);
            end else if (kind < 70) begin
                send_byte(CH_BSL, 1'b0);
                send_byte(esc_byte(), 1'b0);
            end else if (kind < 88) begin
                send_byte(CH_BSL, 1'b0);
                send_byte(CH_LC_U, 1'b0);
                repeat (NumHexDigits) send_byte(hex_char(), 1'b0);
            end else begin
                case ($urandom_range(2))
                    0: begin
                        // short \u run ended by an arbitrary byte
                        send_byte(CH_BSL, 1'b0);
                        send_byte(CH_LC_U, 1'b0);
                        n_digits = $urandom_range(NumHexDigits - 1);
                        repeat (n_digits) send_byte(hex_char(), 1'b0);
                        send_byte(8'($urandom_range(255)), 1'b0);
                    end
                    1: begin
                        if ($urandom_range(1)) send_byte(CH_BSL, 1'b0);
                        send_byte(CH_NUL, 1'b0);
                    end
                    default: send_byte(8'($urandom_range(255)), 1'b1);
                endcase
            end
        end
        if ($urandom_range(9) != 0) send_byte(CH_QUOTE, 1'b0);
        // stray bytes, ignored when the string was closed
        repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    // Output side: check every transfer, then pick the next ready
    initial begin
        t_result got;
        t_result want;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (out_ch.valid && out_ch.ready) begin
                got.unit       = out_ch.unit;
                got.unit_valid = out_ch.unit_valid;
                got.status     = t_status'(out_ch.status);
                if (expected_units.size() == 0) begin
                    $display("%0t: unexpected result unit %h valid %b status %0d",
                             $time, got.unit, got.unit_valid, got.status);
                    fail_count++;
                end else begin
                    want = expected_units.pop_front();
                    if (got.unit !== want.unit || got.unit_valid !== want.unit_valid ||
                        got.status !== want.status) begin
                        $display("%0t: expected unit %h valid %b status %0d, got %h %b %0d",
                                 $time, want.unit, want.unit_valid, want.status,
                                 got.unit, got.unit_valid, got.status);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
            @(posedge i_clk);
        end
    end

    // Input side and run control
    initial begin
        t_result pred;
        int target;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.byte_in <= '0;
        in_ch.first   <= 1'b0;
        str_phase = PH_IDLE;
        hex_cnt   = '0;
        hex_acc   = '0;

        // Byte before any string, missing quote, extremes and each control escape
        add_row(chk_row("x", 1'b0, 16'h0000, 1'b0, ST_IGN));
        add_row(chk_row(8'hFF, 1'b1, 16'h0000, 1'b0, ST_ERR));
        add_row(chk_row(CH_QUOTE, 1'b1, 16'h0000, 1'b0, ST_RUN));
        add_row(chk_row(8'hFF, 1'b0, 16'h00FF, 1'b1, ST_RUN));
        add_row(pred_row(CH_BSL, 1'b0));
        add_row(chk_row(CH_LC_B, 1'b0, CC_BS, 1'b1, ST_RUN));
        add_row(pred_row(CH_BSL, 1'b0));
        add_row(chk_row(CH_LC_FF, 1'b0, CC_FF, 1'b1, ST_RUN));
        add_row(pred_row(CH_BSL, 1'b0));
        add_row(chk_row(CH_LC_N, 1'b0, CC_LF, 1'b1, ST_RUN));
        add_row(pred_row(CH_BSL, 1'b0));
        add_row(chk_row(CH_LC_R, 1'b0, CC_CR, 1'b1, ST_RUN));
        add_row(pred_row(CH_BSL, 1'b0));
        add_row(chk_row(CH_LC_T, 1'b0, CC_HT, 1'b1, ST_RUN));
        // \u with mixed case digits
        add_row(pred_row(CH_BSL, 1'b0));
        add_row(pred_row(CH_LC_U, 1'b0));
        add_row(pred_row("a", 1'b0));
        add_row(pred_row("F", 1'b0));
        add_row(pred_row("0", 1'b0));
        add_row(chk_row("9", 1'b0, 16'hAF09, 1'b1, ST_RUN));
        // restart in the middle of a \u run, hex state must clear
        add_row(pred_row(CH_BSL, 1'b0));
        add_row(pred_row(CH_LC_U, 1'b0));
        add_row(pred_row("7", 1'b0));
        add_row(chk_row(CH_QUOTE, 1'b1, 16'h0000, 1'b0, ST_RUN));
        add_row(chk_row("g", 1'b0, 16'h0067, 1'b1, ST_RUN));
        add_row(chk_row(CH_QUOTE, 1'b0, 16'h0000, 1'b0, ST_OK));
        add_row(chk_row("q", 1'b0, 16'h0000, 1'b0, ST_IGN));
        // quote among hex digits
        add_row(pred_row(CH_QUOTE, 1'b1));
        add_row(pred_row(CH_BSL, 1'b0));
        add_row(pred_row(CH_LC_U, 1'b0));
        add_row(chk_row(CH_QUOTE, 1'b0, 16'h0000, 1'b0, ST_ERR));
        // NUL after backslash, in the body and among hex digits
        add_row(pred_row(CH_QUOTE, 1'b1));
        add_row(pred_row(CH_BSL, 1'b0));
        add_row(chk_row(CH_NUL, 1'b0, 16'h0000, 1'b0, ST_ERR));
        add_row(pred_row(CH_QUOTE, 1'b1));
        add_row(chk_row(CH_NUL, 1'b0, 16'h0000, 1'b0, ST_ERR));
        add_row(pred_row(CH_QUOTE, 1'b1));
        add_row(pred_row(CH_BSL, 1'b0));
        add_row(pred_row(CH_LC_U, 1'b0));
        add_row(pred_row("1", 1'b0));
        add_row(chk_row(CH_NUL, 1'b0, 16'h0000, 1'b0, ST_ERR));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            offer_byte(dir_rows[k].b, dir_rows[k].f);
            unescape_predict(dir_rows[k].b, dir_rows[k].f, pred);
            add_expected(dir_rows[k].typed ? dir_rows[k].res : pred);
        end

        // Random strings: slow sink, then slow source, then full rate
        target = sent_bytes + ITEMS_PER_PH;
        while (sent_bytes < target) random_string();
        src_idle_pct = 86;
        snk_idle_pct = 28;
        target = sent_bytes + ITEMS_PER_PH;
        while (sent_bytes < target) random_string();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        // long sink hold-off with the source still pushing
        hold_left = HOLD_CYCLES;
        target = sent_bytes + ITEMS_PER_PH;
        while (sent_bytes < target) random_string();
        in_ch.valid <= 1'b0;

        while (expected_units.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("json_string_unescape_tb passed");
        end else begin
            $display("json_string_unescape_tb failed");
        end
        $finish;
    end

endmodule
